// ===== src/pgtd_pkg.sv =====
// Shared types, constants and a helper function for the PCM gain and dither block.
// No dependencies; imported by every module under src.

package pgtd_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int DITHER_W = 17;
    localparam int ACC_W    = SAMPLE_W + GAIN_W + 1;
    localparam int QUOT_W   = ACC_W - FRAC_W;

    localparam logic [GAIN_W-1:0] GAIN_UNITY   = 17'h10000;
    localparam logic [31:0]       DITHER_SEED  = 32'd42;

    localparam logic signed [QUOT_W-1:0] SAT16_HI = 26'sd32767;
    localparam logic signed [QUOT_W-1:0] SAT16_LO = -26'sd32768;
    localparam logic signed [QUOT_W-1:0] SAT24_HI = 26'sd8388607;
    localparam logic signed [QUOT_W-1:0] SAT24_LO = -26'sd8388608;

    typedef enum logic [0:0] {
        CFG_GAIN   = 1'b0,
        CFG_FORMAT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_MUTE   = 2'd1,
        MODE_DITHER = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                        mode;
        logic signed [SAMPLE_W-1:0]   sample;
        logic signed [DITHER_W-1:0]   dither;
        logic                         last;
    } item_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

// ===== src/pgtd_dither.sv =====
// Triangular dither source: xorshift32 generator stepped twice per dithered word.
// Depends on pgtd_pkg.

module pgtd_dither
    import pgtd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    output logic signed [DITHER_W-1:0] dither
);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] draw1;
    logic [31:0] draw2;

    always_comb
    begin
        draw1 = xorshift32(state_reg);
        draw2 = xorshift32(draw1);
        dither = $signed({1'b0, draw1[31:16]}) - $signed({1'b0, draw2[31:16]});
        state_next = advance ? draw2 : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DITHER_SEED;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/pgtd_scale.sv =====
// Gain multiply, dither add, truncation toward zero and format saturation; pass and mute modes bypass them.
// Depends on pgtd_pkg.

module pgtd_scale
    import pgtd_pkg::*;
(
    input  item_t                      item,
    input  logic [FRAC_W-1:0]          gain,
    input  logic                       wide,
    output logic signed [SAMPLE_W-1:0] result
);

    logic signed [SAMPLE_W+GAIN_W-1:0] product;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           biased;
    logic signed [QUOT_W-1:0]          quot;
    logic signed [QUOT_W-1:0]          hi;
    logic signed [QUOT_W-1:0]          lo;
    logic signed [QUOT_W-1:0]          clamped;

    always_comb
    begin
        product = (SAMPLE_W+GAIN_W)'(item.sample) * $signed({1'b0, gain});
        acc     = ACC_W'(product) + ACC_W'($signed({item.dither, 1'b0}));
        biased  = acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : ACC_W'(0));
        quot    = biased[ACC_W-1:FRAC_W];
        hi      = wide ? SAT24_HI : SAT16_HI;
        lo      = wide ? SAT24_LO : SAT16_LO;
        if (quot > hi)
        begin
            clamped = hi;
        end
        else if (quot < lo)
        begin
            clamped = lo;
        end
        else
        begin
            clamped = quot;
        end

        unique case (item.mode)
            MODE_PASS:   result = item.sample;
            MODE_MUTE:   result = '0;
            MODE_DITHER: result = clamped[SAMPLE_W-1:0];
            default:     result = '0;
        endcase
    end

endmodule

// ===== src/pcm_gain_tpdf_dither.sv =====
// Top level of the PCM gain stage with triangular dither.
// Depends on pgtd_pkg, pgtd_dither and pgtd_scale.
//
// Usage:
//   Input words (sample_in, last_in_buffer) are taken on in_valid with in_stall low.
//   Result words (sample_out, last_out) leave on out_valid, held while out_stall is high.
//   Configuration goes through cfg_valid/cfg_ready with cfg_index and cfg_data:
//   index 0 is the Q1.16 gain (17 bits), index 1 the sample format (0 = 16-bit,
//   1 = 24-bit). cfg_ready is always high; write only while no words are in flight.
//   A taken word passes the input register and then the result register before out_valid
//   rises; one word is accepted per cycle while in_stall is low, set by the single input
//   register and the single result register.
//   A stall at the output holds the result register and, once the input register
//   is also full, raises in_stall in the same cycle.
//   Reset empties both registers, sets unity gain, 16-bit format, and reseeds the
//   dither generator to 42. The generator steps only on words with 0 < gain < unity.

module pcm_gain_tpdf_dither
    import pgtd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in_buffer,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [GAIN_W-1:0]          cfg_data
);

    logic [GAIN_W-1:0]          gain_reg;
    logic                       wide_reg;
    logic                       stage_valid_reg;
    item_t                      stage_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       last_out_reg;

    logic                       advance;
    logic                       accept;
    logic                       dither_step;
    logic signed [DITHER_W-1:0] dither;
    logic signed [SAMPLE_W-1:0] result;
    item_t                      stage_next;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = stage_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        stage_next.sample = wide_reg ? sample_in
                                     : {{(SAMPLE_W-16){sample_in[15]}}, sample_in[15:0]};
        stage_next.dither = dither;
        stage_next.last   = last_in_buffer;
        priority if (gain_reg[GAIN_W-1])
        begin
            stage_next.mode = MODE_PASS;
        end
        else if (gain_reg == '0)
        begin
            stage_next.mode = MODE_MUTE;
        end
        else
        begin
            stage_next.mode = MODE_DITHER;
        end
        dither_step = accept && (stage_next.mode == MODE_DITHER);
    end

    pgtd_dither u_dither
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (dither_step),
        .dither  (dither)
    );

    pgtd_scale u_scale
    (
        .item   (stage_reg),
        .gain   (gain_reg[FRAC_W-1:0]),
        .wide   (wide_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= GAIN_UNITY;
            wide_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_GAIN:   gain_reg <= cfg_data;
                    CFG_FORMAT: wide_reg <= cfg_data[0];
                    default:    gain_reg <= gain_reg;
                endcase
            end
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
        if (advance && stage_valid_reg)
        begin
            sample_out_reg <= result;
            last_out_reg   <= stage_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

endmodule
